@@ design/gffrp_pkg.sv @@
// Package for the grid first-fit rectangle placer.
// Holds the default grid size, result status codes and sequencer state codes.
// No dependencies.
package gffrp_pkg;

  localparam int unsigned GridColsDefault = 8;
  localparam int unsigned GridRowsDefault = 15;

  localparam int unsigned SlotWidth = 7;
  localparam int unsigned SizeWidth = 4;

  typedef enum logic [1:0] {
    ST_PLACED  = 2'd0,
    ST_NOROOM  = 2'd1,
    ST_CLEARED = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ACC  = 5'b00010,
    S_EVAL = 5'b00100,
    S_MARK = 5'b01000,
    S_RESP = 5'b10000
  } state_e;

endpackage

@@ design/grid_first_fit_rect_placer.sv @@
// Top level of the grid first-fit rectangle placer.
// Uses gffrp_pkg and gffrp_fit_unit.
//
// Usage: a request on the input channel (valid/ready) carries func, a
// rectangle width and height. func = 0 places the rectangle at the first free
// anchor, row-major, where it fits inside the grid without covering an
// occupied cell; the result gives status placed and the anchor index
// (column + row * GRID_COLS, low 7 bits), or status no room and slot 0.
// func = 1 frees the whole map at once and answers status cleared.
// Exactly one result per request, on the output channel (valid/ready).
//
// Timing: a clear goes from idle straight to the result state. A place
// scans one anchor row at a time: the rows under the rectangle are read one
// per cycle into a shared OR accumulator, then the columns are searched.
// Marking writes h rows, one per cycle.
// One request is worked on at a time; in_ready_o is high only when idle.
// A finished result sits in an output register; while the receiver stalls
// the block still takes the next request, but holds its result until the
// register is free. Reset frees every cell and drops any pending result.
module grid_first_fit_rect_placer #(
  parameter int unsigned GRID_COLS = gffrp_pkg::GridColsDefault,
  parameter int unsigned GRID_ROWS = gffrp_pkg::GridRowsDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            func_i,
  input  logic [gffrp_pkg::SizeWidth-1:0] rect_width_i,
  input  logic [gffrp_pkg::SizeWidth-1:0] rect_height_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [1:0]                      status_o,
  output logic [gffrp_pkg::SlotWidth-1:0] slot_o
);

  localparam int unsigned ColW  = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int unsigned RowW  = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int unsigned MaskW = GRID_COLS + 16;
  localparam int unsigned SzW   = gffrp_pkg::SizeWidth;
  localparam int unsigned SlW   = gffrp_pkg::SlotWidth;

  gffrp_pkg::state_e  state_q, state_d;
  gffrp_pkg::status_e res_status_q, res_status_d;
  gffrp_pkg::status_e status_q, status_d;

  logic [GRID_COLS-1:0] map_q [GRID_ROWS];
  logic [GRID_COLS-1:0] acc_q, acc_d;
  logic [GRID_COLS-1:0] anchor_q, anchor_d;
  logic [GRID_COLS-1:0] mask_q, mask_d;
  logic [RowW-1:0]      row_q, row_d;
  logic [SzW-1:0]       cnt_q, cnt_d;
  logic [SzW-1:0]       w_q, w_d;
  logic [SzW-1:0]       h_q, h_d;
  logic [SlW-1:0]       base_q, base_d;
  logic [SlW-1:0]       res_slot_q, res_slot_d;
  logic [SlW-1:0]       slot_q, slot_d;
  logic                 out_valid_q, out_valid_d;

  logic                 accept;
  logic                 zero_size;
  logic [SzW:0]         h_min;
  logic [SzW:0]         cnt_inc;
  logic [RowW:0]        rd_sum;
  logic [RowW-1:0]      rd_idx;
  logic [GRID_COLS-1:0] rd_row;
  logic [7:0]           next_end;
  logic                 fit_found;
  logic [ColW-1:0]      fit_col;
  logic [MaskW-1:0]     mark_wide;
  logic                 map_clear;
  logic                 map_write;

  assign in_ready_o = (state_q == gffrp_pkg::S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  assign zero_size = (w_q == '0) || (h_q == '0);
  assign h_min     = (h_q == '0) ? (SzW+1)'(1) : {1'b0, h_q};
  assign cnt_inc   = {1'b0, cnt_q} + (SzW+1)'(1);
  assign rd_sum    = (RowW+1)'(row_q) + (RowW+1)'(cnt_q);
  assign rd_idx    = rd_sum[RowW-1:0];
  assign rd_row    = map_q[rd_idx];
  assign next_end  = 8'(row_q) + 8'd1 + 8'(h_min);
  assign mark_wide = ((MaskW'(1) << w_q) - MaskW'(1)) << fit_col;

  gffrp_fit_unit #(
    .GRID_COLS(GRID_COLS)
  ) u_fit (
    .acc_i      (acc_q),
    .anchor_i   (anchor_q),
    .width_i    (w_q),
    .zero_size_i(zero_size),
    .found_o    (fit_found),
    .col_o      (fit_col)
  );

  always_comb begin
    state_d      = state_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    acc_d        = acc_q;
    anchor_d     = anchor_q;
    mask_d       = mask_q;
    row_d        = row_q;
    cnt_d        = cnt_q;
    w_d          = w_q;
    h_d          = h_q;
    base_d       = base_q;
    out_valid_d  = out_valid_q;
    status_d     = status_q;
    slot_d       = slot_q;
    map_clear    = 1'b0;
    map_write    = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      gffrp_pkg::S_IDLE: begin
        if (accept) begin
          w_d        = rect_width_i;
          h_d        = rect_height_i;
          row_d      = '0;
          cnt_d      = '0;
          acc_d      = '0;
          base_d     = '0;
          res_slot_d = '0;
          if (func_i) begin
            map_clear    = 1'b1;
            res_status_d = gffrp_pkg::ST_CLEARED;
            state_d      = gffrp_pkg::S_RESP;
          end else if ((5'(rect_width_i) > 5'(GRID_COLS)) ||
                       (6'(rect_height_i) > 6'(GRID_ROWS))) begin
            res_status_d = gffrp_pkg::ST_NOROOM;
            state_d      = gffrp_pkg::S_RESP;
          end else begin
            state_d = gffrp_pkg::S_ACC;
          end
        end
      end
      gffrp_pkg::S_ACC: begin
        acc_d = acc_q | rd_row;
        if (cnt_q == '0) begin
          anchor_d = rd_row;
        end
        cnt_d = cnt_inc[SzW-1:0];
        if (cnt_inc >= h_min) begin
          state_d = gffrp_pkg::S_EVAL;
        end
      end
      gffrp_pkg::S_EVAL: begin
        cnt_d = '0;
        acc_d = '0;
        if (fit_found) begin
          mask_d       = mark_wide[GRID_COLS-1:0];
          res_status_d = gffrp_pkg::ST_PLACED;
          res_slot_d   = base_q + SlW'(fit_col);
          state_d      = zero_size ? gffrp_pkg::S_RESP : gffrp_pkg::S_MARK;
        end else if (next_end > 8'(GRID_ROWS)) begin
          res_status_d = gffrp_pkg::ST_NOROOM;
          res_slot_d   = '0;
          state_d      = gffrp_pkg::S_RESP;
        end else begin
          // advance to the next anchor row
          row_d   = row_q + RowW'(1);
          base_d  = base_q + SlW'(GRID_COLS);
          state_d = gffrp_pkg::S_ACC;
        end
      end
      gffrp_pkg::S_MARK: begin
        map_write = 1'b1;
        cnt_d     = cnt_inc[SzW-1:0];
        if (cnt_inc == {1'b0, h_q}) begin
          state_d = gffrp_pkg::S_RESP;
        end
      end
      gffrp_pkg::S_RESP: begin
        // hold the result until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          status_d    = res_status_q;
          slot_d      = res_slot_q;
          state_d     = gffrp_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = gffrp_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gffrp_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < GRID_ROWS; r++) begin
        map_q[r] <= '0;
      end
    end else if (map_clear) begin
      for (int r = 0; r < GRID_ROWS; r++) begin
        map_q[r] <= '0;
      end
    end else if (map_write) begin
      map_q[rd_idx] <= rd_row | mask_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    acc_q        <= acc_d;
    anchor_q     <= anchor_d;
    mask_q       <= mask_d;
    row_q        <= row_d;
    cnt_q        <= cnt_d;
    w_q          <= w_d;
    h_q          <= h_d;
    base_q       <= base_d;
    status_q     <= status_d;
    slot_q       <= slot_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign slot_o      = slot_q;

  // A placed rectangle only ever covers free cells.
  a_mark_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gffrp_pkg::S_MARK) |-> ((rd_row & mask_q) == '0))
    else $error("marking an occupied cell");

  // Only placed results carry an anchor index.
  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != gffrp_pkg::ST_PLACED)) |-> (slot_o == '0))
    else $error("nonzero slot on a result that was not placed");

  // A clear request empties the map by the next cycle (checked on row 0) and enters the result state.
  a_clear_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && func_i) |=> (map_q[0] == '0 && state_q == gffrp_pkg::S_RESP))
    else $error("clear request did not empty the map");

  // The row walk never reads past the bottom of the grid.
  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == gffrp_pkg::S_ACC) || (state_q == gffrp_pkg::S_MARK))
      |-> (rd_sum < (RowW+1)'(GRID_ROWS)))
    else $error("row index out of grid");

  // A pending result is never dropped: leaving the result state loads it.
  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gffrp_pkg::S_RESP && state_d == gffrp_pkg::S_IDLE) |=> out_valid_o)
    else $error("result lost on its way to the output register");

endmodule

@@ design/gffrp_fit_unit.sv @@
// Column fit search for one anchor row of the placer.
// Takes the OR of the rows under the rectangle and the anchor row, and finds
// the first free column where the rectangle fits. Uses gffrp_pkg.
module gffrp_fit_unit #(
  parameter int unsigned GRID_COLS = gffrp_pkg::GridColsDefault,
  localparam int unsigned ColW = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1
) (
  input  logic [GRID_COLS-1:0]            acc_i,
  input  logic [GRID_COLS-1:0]            anchor_i,
  input  logic [gffrp_pkg::SizeWidth-1:0] width_i,
  input  logic                            zero_size_i,
  output logic                            found_o,
  output logic [ColW-1:0]                 col_o
);

  localparam int unsigned MaskW = GRID_COLS + 16;

  logic [MaskW-1:0]     wmask;
  logic [GRID_COLS-1:0] fit;

  assign wmask = (MaskW'(1) << width_i) - MaskW'(1);

  // A zero-sized rectangle covers no cell but must still stay inside the grid.
  for (genvar c = 0; c < GRID_COLS; c++) begin : g_lane
    logic [MaskW-1:0] win;
    logic             in_grid;
    assign win     = wmask << c;
    assign in_grid = (6'(c) + 6'(width_i)) <= 6'(GRID_COLS);
    assign fit[c]  = !anchor_i[c] && in_grid &&
                     (zero_size_i || ((MaskW'(acc_i) & win) == '0));
  end

  // Lowest fitting column wins.
  always_comb begin
    found_o = 1'b0;
    col_o   = '0;
    for (int c = GRID_COLS - 1; c >= 0; c--) begin
      if (fit[c]) begin
        found_o = 1'b1;
        col_o   = ColW'(c);
      end
    end
  end

endmodule
